/* hw/rtl/lsfg_pkg.sv */
package lsfg_pkg;

   // Strip geometry
   localparam int LED_COUNT = 12;
   localparam int FRAME_LEN = 4 * (LED_COUNT + 2);
   localparam int IDX_W     = $clog2(FRAME_LEN);

   // Field widths
   localparam int COL_W     = 8;
   localparam int DUR_W     = 16;
   localparam int ACT_W     = 3;
   localparam int MODE_W    = 3;
   localparam int PROD_W    = COL_W + DUR_W;
   localparam int DIV_Q_W   = COL_W;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W);

   // Frame bytes
   localparam logic [COL_W-1:0] BRIGHT_MAX = 8'd31;
   localparam logic [COL_W-1:0] LED_HDR    = 8'hE0;
   localparam logic [COL_W-1:0] END_BYTE   = 8'hFF;
   localparam logic [COL_W-1:0] HEAD_BYTE  = 8'h00;

   // Byte slot within one LED's group of four
   localparam logic [1:0] SLOT_BRIGHT = 2'd0;
   localparam logic [1:0] SLOT_BLUE   = 2'd1;
   localparam logic [1:0] SLOT_GREEN  = 2'd2;
   localparam logic [1:0] SLOT_RED    = 2'd3;

   // Colour array index
   localparam int CI_BRIGHT = 0;
   localparam int CI_RED    = 1;
   localparam int CI_GREEN  = 2;
   localparam int CI_BLUE   = 3;

   // Configuration
   localparam int                    CSR_ADDR_W      = 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_REFRESH    = 2'd0;
   localparam logic [COL_W-1:0]      REFRESH_DEFAULT = 8'd20;

   // Action codes
   localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_OFF   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SET   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RAMP  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_BLINK = 3'd4;

   // Effect modes
   localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_OFF   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SET   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RAMP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BLINK = 3'd4;

   // Micro operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP          = 4'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT       = 4'd1;
   localparam logic [OP_W-1:0] OP_CMD_OFF      = 4'd2;
   localparam logic [OP_W-1:0] OP_CMD_SET      = 4'd3;
   localparam logic [OP_W-1:0] OP_CMD_RAMP     = 4'd4;
   localparam logic [OP_W-1:0] OP_CMD_BLINK    = 4'd5;
   localparam logic [OP_W-1:0] OP_LOAD_REFRESH = 4'd6;
   localparam logic [OP_W-1:0] OP_BLINK_LOAD   = 4'd7;
   localparam logic [OP_W-1:0] OP_CH_CLEAR     = 4'd8;
   localparam logic [OP_W-1:0] OP_MUL          = 4'd9;
   localparam logic [OP_W-1:0] OP_DIV_START    = 4'd10;
   localparam logic [OP_W-1:0] OP_RAMP_WRITE   = 4'd11;
   localparam logic [OP_W-1:0] OP_RAMP_ADV     = 4'd12;
   localparam logic [OP_W-1:0] OP_WAIT_DEC     = 4'd13;
   localparam logic [OP_W-1:0] OP_EMIT         = 4'd14;

   // Next address selection
   localparam int JK_W = 2;
   localparam logic [JK_W-1:0] JK_COND   = 2'd0;
   localparam logic [JK_W-1:0] JK_ACTION = 2'd1;
   localparam logic [JK_W-1:0] JK_MODE   = 2'd2;

   // Jump conditions; false falls through to the next address
   localparam int CC_W = 3;
   localparam logic [CC_W-1:0] CC_ALWAYS    = 3'd0;
   localparam logic [CC_W-1:0] CC_NEVER     = 3'd1;
   localparam logic [CC_W-1:0] CC_WAIT_NZ   = 3'd2;
   localparam logic [CC_W-1:0] CC_CH_MORE   = 3'd3;
   localparam logic [CC_W-1:0] CC_BYTE_MORE = 3'd4;
   localparam logic [CC_W-1:0] CC_DIV_BUSY  = 3'd5;

   // Program addresses
   localparam int UPC_W = 5;
   localparam logic [UPC_W-1:0] UA_FETCH      = 5'd0;
   localparam logic [UPC_W-1:0] UA_ACT_BASE   = 5'd1;
   localparam logic [UPC_W-1:0] UA_ACT_TICK   = 5'd1;
   localparam logic [UPC_W-1:0] UA_ACT_OFF    = 5'd2;
   localparam logic [UPC_W-1:0] UA_ACT_SET    = 5'd3;
   localparam logic [UPC_W-1:0] UA_ACT_RAMP   = 5'd4;
   localparam logic [UPC_W-1:0] UA_ACT_BLINK  = 5'd5;
   localparam logic [UPC_W-1:0] UA_MODE_BASE  = 5'd9;
   localparam logic [UPC_W-1:0] UA_MODE_OFF   = 5'd10;
   localparam logic [UPC_W-1:0] UA_MODE_SET   = 5'd11;
   localparam logic [UPC_W-1:0] UA_MODE_RAMP  = 5'd12;
   localparam logic [UPC_W-1:0] UA_MODE_BLINK = 5'd13;
   localparam logic [UPC_W-1:0] UA_REFRESH    = 5'd17;
   localparam logic [UPC_W-1:0] UA_REF_LOAD   = 5'd18;
   localparam logic [UPC_W-1:0] UA_BLINK      = 5'd19;
   localparam logic [UPC_W-1:0] UA_BLINK_LOAD = 5'd20;
   localparam logic [UPC_W-1:0] UA_MUL        = 5'd21;
   localparam logic [UPC_W-1:0] UA_DIV_START  = 5'd22;
   localparam logic [UPC_W-1:0] UA_DIV_WAIT   = 5'd23;
   localparam logic [UPC_W-1:0] UA_RAMP_WRITE = 5'd24;
   localparam logic [UPC_W-1:0] UA_RAMP_ADV   = 5'd25;
   localparam logic [UPC_W-1:0] UA_DEC        = 5'd26;
   localparam logic [UPC_W-1:0] UA_EMIT       = 5'd27;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [JK_W-1:0]  kind;
      logic [CC_W-1:0]  cond;
      logic [UPC_W-1:0] target;
   } uword_type;

   function automatic uword_type uw(input logic [OP_W-1:0] op, input logic [JK_W-1:0] kind,
                                    input logic [CC_W-1:0] cond,
                                    input logic [UPC_W-1:0] target);
      uword_type w;
      w.op     = op;
      w.kind   = kind;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // Control store
   function automatic uword_type ucode(input logic [UPC_W-1:0] addr);
      uword_type w;
      case (addr)
         UA_FETCH:      w = uw(OP_ACCEPT,       JK_ACTION, CC_ALWAYS,    UA_ACT_BASE);
         UA_ACT_TICK:   w = uw(OP_NOP,          JK_MODE,   CC_ALWAYS,    UA_MODE_BASE);
         UA_ACT_OFF:    w = uw(OP_CMD_OFF,      JK_COND,   CC_ALWAYS,    UA_FETCH);
         UA_ACT_SET:    w = uw(OP_CMD_SET,      JK_COND,   CC_ALWAYS,    UA_FETCH);
         UA_ACT_RAMP:   w = uw(OP_CMD_RAMP,     JK_COND,   CC_ALWAYS,    UA_FETCH);
         UA_ACT_BLINK:  w = uw(OP_CMD_BLINK,    JK_COND,   CC_ALWAYS,    UA_FETCH);
         UA_MODE_OFF:   w = uw(OP_NOP,          JK_COND,   CC_ALWAYS,    UA_REFRESH);
         UA_MODE_SET:   w = uw(OP_NOP,          JK_COND,   CC_ALWAYS,    UA_REFRESH);
         UA_MODE_RAMP:  w = uw(OP_CH_CLEAR,     JK_COND,   CC_ALWAYS,    UA_MUL);
         UA_MODE_BLINK: w = uw(OP_NOP,          JK_COND,   CC_ALWAYS,    UA_BLINK);
         UA_REFRESH:    w = uw(OP_NOP,          JK_COND,   CC_WAIT_NZ,   UA_DEC);
         UA_REF_LOAD:   w = uw(OP_LOAD_REFRESH, JK_COND,   CC_ALWAYS,    UA_EMIT);
         UA_BLINK:      w = uw(OP_NOP,          JK_COND,   CC_WAIT_NZ,   UA_DEC);
         UA_BLINK_LOAD: w = uw(OP_BLINK_LOAD,   JK_COND,   CC_ALWAYS,    UA_EMIT);
         UA_MUL:        w = uw(OP_MUL,          JK_COND,   CC_NEVER,     UA_FETCH);
         UA_DIV_START:  w = uw(OP_DIV_START,    JK_COND,   CC_NEVER,     UA_FETCH);
         UA_DIV_WAIT:   w = uw(OP_NOP,          JK_COND,   CC_DIV_BUSY,  UA_DIV_WAIT);
         UA_RAMP_WRITE: w = uw(OP_RAMP_WRITE,   JK_COND,   CC_CH_MORE,   UA_MUL);
         UA_RAMP_ADV:   w = uw(OP_RAMP_ADV,     JK_COND,   CC_ALWAYS,    UA_EMIT);
         UA_DEC:        w = uw(OP_WAIT_DEC,     JK_COND,   CC_ALWAYS,    UA_FETCH);
         UA_EMIT:       w = uw(OP_EMIT,         JK_COND,   CC_BYTE_MORE, UA_EMIT);
         default:       w = uw(OP_NOP,          JK_COND,   CC_ALWAYS,    UA_FETCH);
      endcase
      return w;
   endfunction

   function automatic logic [COL_W-1:0] clamp_bright(input logic [COL_W-1:0] b);
      return (b < BRIGHT_MAX) ? b : BRIGHT_MAX;
   endfunction

endpackage

/* hw/rtl/lsfg_div.sv */
// Restoring divider, one quotient bit per cycle.
// The caller guarantees dividend < 2**DIV_Q_W * divisor, so the quotient
// fits in DIV_Q_W bits and the upper dividend bits start as the remainder.
module lsfg_div
   import lsfg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PROD_W-1:0]  dividend,
   input  logic [DUR_W-1:0]   divisor,
   output logic               busy,
   output logic [DIV_Q_W-1:0] quotient
);

   logic [DUR_W-1:0]     rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [DUR_W:0]       trial;
   logic [DUR_W:0]       trial_sub;
   logic                 fits;

   // One trial subtraction
   assign trial     = {rem_ff, quo_ff[DIV_Q_W-1]};
   assign trial_sub = trial - {1'b0, divisor};
   assign fits      = (trial >= {1'b0, divisor});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = dividend[PROD_W-1:DIV_Q_W];
         quo_in  = dividend[DIV_Q_W-1:0];
         cnt_in  = DIV_CNT_W'(DIV_Q_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DUR_W-1:0] : trial[DUR_W-1:0];
         quo_in = {quo_ff[DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

/* hw/rtl/led_strip_effect_frame_generator_unit.sv */
// Channel  Direction  Ports                                   Moves
// req      in         req_valid/req_ready, req_action ...     one command or tick item
// rsp      out        rsp_valid/rsp_ready, rsp_frame_byte ... one frame byte item
// csr      in/out     csr_psel/penable/pwrite/paddr/pwdata    refresh_ticks register
//
// A command or unused item runs only the fetch and action steps; a tick also runs the
// step of the current mode. An off, set or blink frame goes out one byte per cycle while rsp is not stalled.
// In ramp mode each of the four colour channels goes through the shared 8-step divider
// before the frame is sent.
// Reset is synchronous and clears the effect state; no clearing pass is needed.
// A stalled rsp holds the sequencer on the emit step; req is taken only at fetch.
module led_strip_effect_frame_generator_unit
   import lsfg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [COL_W-1:0]      req_brightness,
   input  logic [COL_W-1:0]      req_red,
   input  logic [COL_W-1:0]      req_green,
   input  logic [COL_W-1:0]      req_blue,
   input  logic [DUR_W-1:0]      req_duration,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COL_W-1:0]      rsp_frame_byte,
   output logic                  rsp_frame_end,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Sequencer
   logic [UPC_W-1:0]  upc_ff, upc_in;
   uword_type         uop;
   logic              hold;
   logic              cond_ok;

   // Latched item payload
   logic [COL_W-1:0]  col_ff [4];
   logic [COL_W-1:0]  col_in [4];
   logic [DUR_W-1:0]  dur_ff, dur_in;

   // Effect state
   logic [COL_W-1:0]  refresh_ff, refresh_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [COL_W-1:0]  cur_ff [4];
   logic [COL_W-1:0]  cur_in [4];
   logic [COL_W-1:0]  start_ff [4];
   logic [COL_W-1:0]  start_in [4];
   logic [COL_W-1:0]  tgt_ff [4];
   logic [COL_W-1:0]  tgt_in [4];
   logic [DUR_W-1:0]  step_ff, step_in;
   logic [DUR_W-1:0]  period_ff, period_in;
   logic              phase_ff, phase_in;
   logic [DUR_W-1:0]  wait_ff, wait_in;

   // Ramp datapath
   logic [1:0]         ch_ff, ch_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               down_ff, down_in;
   logic [COL_W-1:0]   ch_start;
   logic [COL_W-1:0]   ch_tgt;
   logic [COL_W-1:0]   ch_diff;
   logic [COL_W-1:0]   ramp_val;
   logic [PROD_W-1:0]  div_dividend;
   logic               div_start;
   logic               div_busy;
   logic [DIV_Q_W-1:0] div_quot;

   // Frame output
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic              rsp_end_ff, rsp_end_in;
   logic [COL_W-1:0]  frame_byte;
   logic              frame_last;

   logic              csr_write;

   assign uop = ucode(upc_ff);

   // Sequencer holds on fetch without an item and on emit with the output full
   assign hold = ((uop.op == OP_ACCEPT) && !req_valid) ||
                 ((uop.op == OP_EMIT) && rsp_valid_ff && !rsp_ready);

   always_comb begin
      case (uop.cond)
         CC_ALWAYS:    cond_ok = 1'b1;
         CC_NEVER:     cond_ok = 1'b0;
         CC_WAIT_NZ:   cond_ok = (wait_ff != '0);
         CC_CH_MORE:   cond_ok = (ch_ff != 2'd3);
         CC_BYTE_MORE: cond_ok = (idx_ff != IDX_W'(FRAME_LEN - 1));
         CC_DIV_BUSY:  cond_ok = div_busy;
         default:      cond_ok = 1'b1;
      endcase
   end

   always_comb begin
      if (hold) begin
         upc_in = upc_ff;
      end else begin
         case (uop.kind)
            JK_ACTION: upc_in = uop.target + UPC_W'(req_action);
            JK_MODE:   upc_in = uop.target + UPC_W'(mode_ff);
            JK_COND:   upc_in = cond_ok ? uop.target : UPC_W'(upc_ff + 1'b1);
            default:   upc_in = UA_FETCH;
         endcase
      end
   end

   // Ramp channel operands
   assign ch_start     = start_ff[ch_ff];
   assign ch_tgt       = tgt_ff[ch_ff];
   assign ch_diff      = (ch_tgt < ch_start) ? (ch_start - ch_tgt) : (ch_tgt - ch_start);
   // Downward ramps round the step toward the target: add divisor - 1
   assign div_dividend = prod_ff + (down_ff ? PROD_W'(period_ff - 1'b1) : '0);
   assign div_start    = (uop.op == OP_DIV_START);
   assign ramp_val     = (period_ff == '0) ? ch_tgt :
                         down_ff ? (ch_start - div_quot) : (ch_start + div_quot);

   lsfg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (period_ff),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // Frame byte for the current position
   always_comb begin
      frame_last = (idx_ff == IDX_W'(FRAME_LEN - 1));
      if (idx_ff < IDX_W'(4)) begin
         frame_byte = HEAD_BYTE;
      end else if (idx_ff >= IDX_W'(FRAME_LEN - 4)) begin
         frame_byte = END_BYTE;
      end else begin
         case (idx_ff[1:0])
            SLOT_BRIGHT: frame_byte = LED_HDR | clamp_bright(cur_ff[CI_BRIGHT]);
            SLOT_BLUE:   frame_byte = cur_ff[CI_BLUE];
            SLOT_GREEN:  frame_byte = cur_ff[CI_GREEN];
            SLOT_RED:    frame_byte = cur_ff[CI_RED];
            default:     frame_byte = HEAD_BYTE;
         endcase
      end
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr == ADDR_REFRESH);

   // Datapath controlled by the micro operation
   always_comb begin
      col_in       = col_ff;
      dur_in       = dur_ff;
      refresh_in   = refresh_ff;
      mode_in      = mode_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      tgt_in       = tgt_ff;
      step_in      = step_ff;
      period_in    = period_ff;
      phase_in     = phase_ff;
      wait_in      = wait_ff;
      ch_in        = ch_ff;
      prod_in      = prod_ff;
      down_in      = down_ff;
      idx_in       = '0;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;

      if (csr_write) begin
         refresh_in = csr_pwdata[COL_W-1:0];
      end

      case (uop.op)
         OP_ACCEPT: begin
            col_in[CI_BRIGHT] = clamp_bright(req_brightness);
            col_in[CI_RED]    = req_red;
            col_in[CI_GREEN]  = req_green;
            col_in[CI_BLUE]   = req_blue;
            dur_in            = req_duration;
         end
         OP_CMD_OFF: begin
            for (int i = 0; i < 4; i++) cur_in[i] = '0;
            mode_in = MODE_OFF;
            wait_in = '0;
         end
         OP_CMD_SET: begin
            cur_in  = col_ff;
            mode_in = MODE_SET;
            wait_in = '0;
         end
         OP_CMD_RAMP: begin
            start_in  = cur_ff;
            tgt_in    = col_ff;
            step_in   = '0;
            period_in = dur_ff;
            mode_in   = MODE_RAMP;
         end
         OP_CMD_BLINK: begin
            tgt_in    = col_ff;
            period_in = dur_ff;
            phase_in  = 1'b0;
            wait_in   = '0;
            mode_in   = MODE_BLINK;
         end
         OP_LOAD_REFRESH: begin
            wait_in = (refresh_ff == '0) ? '0 : DUR_W'(refresh_ff - 1'b1);
         end
         OP_BLINK_LOAD: begin
            wait_in = (period_ff == '0) ? '0 : (period_ff - 1'b1);
            for (int i = 0; i < 4; i++) cur_in[i] = phase_ff ? tgt_ff[i] : '0;
            phase_in = ~phase_ff;
         end
         OP_CH_CLEAR: begin
            ch_in = '0;
         end
         OP_MUL: begin
            down_in = (ch_tgt < ch_start);
            prod_in = PROD_W'(ch_diff) * PROD_W'(step_ff);
         end
         OP_RAMP_WRITE: begin
            cur_in[ch_ff] = ramp_val;
            ch_in         = ch_ff + 1'b1;
         end
         OP_RAMP_ADV: begin
            if (step_ff >= period_ff) begin
               mode_in = MODE_IDLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         OP_WAIT_DEC: begin
            wait_in = wait_ff - 1'b1;
         end
         OP_EMIT: begin
            if (hold) begin
               idx_in = idx_ff;
            end else begin
               idx_in       = IDX_W'(idx_ff + 1'b1);
               rsp_valid_in = 1'b1;
               rsp_byte_in  = frame_byte;
               rsp_end_in   = frame_last;
            end
         end
         default: begin
         end
      endcase
   end

   // Payload registers
   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      dur_ff      <= dur_in;
      ch_ff       <= ch_in;
      prod_ff     <= prod_in;
      down_ff     <= down_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   // Control and effect state
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UA_FETCH;
         refresh_ff   <= REFRESH_DEFAULT;
         mode_ff      <= MODE_IDLE;
         step_ff      <= '0;
         period_ff    <= '0;
         phase_ff     <= 1'b0;
         wait_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            cur_ff[i]   <= '0;
            start_ff[i] <= '0;
            tgt_ff[i]   <= '0;
         end
      end else begin
         upc_ff       <= upc_in;
         refresh_ff   <= refresh_in;
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         period_ff    <= period_in;
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         start_ff     <= start_in;
         tgt_ff       <= tgt_in;
      end
   end

   assign req_ready      = (uop.op == OP_ACCEPT);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_frame_end  = rsp_end_ff;
   assign csr_pready     = 1'b1;
   assign csr_prdata     = (csr_paddr == ADDR_REFRESH) ? {24'd0, refresh_ff} : 32'd0;

`ifndef NO_ASSERTIONS
   // A new output item only comes from an emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (!$past(rsp_valid_ff) || $past(rsp_ready))) |->
         $past(uop.op == OP_EMIT))
      else $error("output item without emit step");

   // The divider is never restarted while it is still working
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // A ramp never steps past its length
   a_ramp_step_bound: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_RAMP) |-> (step_ff <= period_ff))
      else $error("ramp step beyond duration");

   // The last byte of a frame is an end byte
   a_frame_end_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_end_ff) |-> (rsp_byte_ff == END_BYTE))
      else $error("frame end on wrong byte");
`endif

endmodule

/* tb/tb_led_strip_effect_frame_generator_unit.sv */
`timescale 1ns / 100ps

module tb_led_strip_effect_frame_generator_unit;
   import lsfg_pkg::*;

   // Action codes the block must ignore
   localparam logic [ACT_W-1:0] ACT_UNUSED_LO = ACT_BLINK + 3'd1;
   localparam logic [ACT_W-1:0] ACT_UNUSED_HI = '1;

   // Cycles for a command or a frameless tick to retire after the last byte
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_CHUNKS  = 4;
   localparam int CHUNK_ITEMS    = 18;

   typedef struct {
      logic [ACT_W-1:0] action;
      logic [COL_W-1:0] brightness;
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] blue;
      logic [DUR_W-1:0] duration;
   } strip_cmd_type;

   typedef struct {
      logic [COL_W-1:0] frame_byte;
      logic             frame_end;
   } frame_beat_type;

   // brightness, red, green, blue
   typedef logic [COL_W-1:0] pixel_type [4];

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [ACT_W-1:0]      req_action     = ACT_TICK;
   logic [COL_W-1:0]      req_brightness = '0;
   logic [COL_W-1:0]      req_red        = '0;
   logic [COL_W-1:0]      req_green      = '0;
   logic [COL_W-1:0]      req_blue       = '0;
   logic [DUR_W-1:0]      req_duration   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [COL_W-1:0]      rsp_frame_byte;
   logic                  rsp_frame_end;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [31:0]           csr_pwdata     = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   led_strip_effect_frame_generator_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_brightness (req_brightness),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_duration   (req_duration),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_end  (rsp_frame_end),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Effect state mirrored by the predictor
   logic [COL_W-1:0] refresh_setting;
   logic [MODE_W-1:0] effect_mode;
   pixel_type        shown_colour;
   pixel_type        ramp_from;
   pixel_type        goal_colour;
   logic [DUR_W-1:0] ramp_step;
   logic [DUR_W-1:0] effect_period;
   logic             blink_lit_next;
   logic [DUR_W-1:0] ticks_to_frame;

   frame_beat_type expected_bytes [$];
   int          fail_count   = 0;
   int          quiet_cycles = 0;
   int          rsp_hold_req = 0;
   bit          sender_gaps  = 1'b1;

   // Receiver pacing state
   int pace_left = 0;
   bit pace_on   = 1'b0;

   //--------------------------------------------------------------------------
   // Predictor
   //--------------------------------------------------------------------------
   function automatic logic [COL_W-1:0] bright_limit(input logic [COL_W-1:0] b);
      return (b < 8'd31) ? b : 8'd31;
   endfunction

   function automatic void model_reset();
      refresh_setting = 8'd20;   // register default
      effect_mode     = MODE_IDLE;
      shown_colour    = '{default: '0};
      ramp_from       = '{default: '0};
      goal_colour     = '{default: '0};
      ramp_step       = '0;
      effect_period   = '0;
      blink_lit_next  = 1'b0;
      ticks_to_frame  = '0;
   endfunction

   // floor of start + (goal - start) * step / len, exact in both directions
   function automatic logic [COL_W-1:0] interp_channel(input logic [COL_W-1:0] s,
                                                      input logic [COL_W-1:0] t,
                                                      input logic [DUR_W-1:0] k,
                                                      input logic [DUR_W-1:0] d);
      int unsigned span;
      if (d == 0) return t;
      if (t >= s) begin
         span = t - s;
         return COL_W'(s + (span * k) / d);
      end
      span = s - t;
      return COL_W'(s - ((span * k + d - 1) / d));
   endfunction

   function automatic void push_byte(input logic [COL_W-1:0] b, input logic last);
      frame_beat_type beat;
      beat.frame_byte = b;
      beat.frame_end  = last;
      expected_bytes.push_back(beat);
   endfunction

   // Whole strip frame for the colour now shown
   function automatic void queue_frame();
      for (int i = 0; i < 4; i++) push_byte(HEAD_BYTE, 1'b0);
      for (int led = 0; led < LED_COUNT; led++) begin
         push_byte(LED_HDR | bright_limit(shown_colour[CI_BRIGHT]), 1'b0);
         push_byte(shown_colour[CI_BLUE], 1'b0);
         push_byte(shown_colour[CI_GREEN], 1'b0);
         push_byte(shown_colour[CI_RED], 1'b0);
      end
      for (int i = 0; i < 4; i++) push_byte(END_BYTE, i == 3);
   endfunction

   function automatic void predict_tick();
      case (effect_mode)
         MODE_OFF, MODE_SET: begin
            if (ticks_to_frame != 0) begin
               ticks_to_frame--;
            end else begin
               ticks_to_frame = (refresh_setting == 0) ? '0 :
                                DUR_W'(refresh_setting - 1'b1);
               queue_frame();
            end
         end
         MODE_RAMP: begin
            for (int i = 0; i < 4; i++)
               shown_colour[i] = interp_channel(ramp_from[i], goal_colour[i], ramp_step,
                                                effect_period);
            if (ramp_step >= effect_period) effect_mode = MODE_IDLE;
            else ramp_step++;
            queue_frame();
         end
         MODE_BLINK: begin
            if (ticks_to_frame != 0) begin
               ticks_to_frame--;
            end else begin
               ticks_to_frame = (effect_period == 0) ? '0 : effect_period - 1'b1;
               if (blink_lit_next) shown_colour = goal_colour;
               else shown_colour = '{default: '0};
               blink_lit_next = ~blink_lit_next;
               queue_frame();
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_item(input strip_cmd_type c);
      pixel_type col;
      col[CI_BRIGHT] = bright_limit(c.brightness);
      col[CI_RED]    = c.red;
      col[CI_GREEN]  = c.green;
      col[CI_BLUE]   = c.blue;
      case (c.action)
         ACT_TICK: predict_tick();
         ACT_OFF: begin
            shown_colour   = '{default: '0};
            effect_mode    = MODE_OFF;
            ticks_to_frame = '0;
         end
         ACT_SET: begin
            shown_colour   = col;
            effect_mode    = MODE_SET;
            ticks_to_frame = '0;
         end
         ACT_RAMP: begin
            ramp_from     = shown_colour;
            goal_colour   = col;
            ramp_step     = '0;
            effect_period = c.duration;
            effect_mode   = MODE_RAMP;
         end
         ACT_BLINK: begin
            goal_colour    = col;
            effect_period  = c.duration;
            blink_lit_next = 1'b0;
            ticks_to_frame = '0;
            effect_mode    = MODE_BLINK;
         end
         default: ;   // unused codes leave everything alone
      endcase
   endfunction

   //--------------------------------------------------------------------------
   // Result side: pacing, checking, watchdog
   //--------------------------------------------------------------------------
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_run();
      if ($urandom_range(0, 4) == 0) return $urandom_range(60, 200);
      return $urandom_range(1, 30);
   endfunction

   // Ready alternates between runs and stalls; a hold request forces a long stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_hold_req != 0) begin
            pace_on      = 1'b0;
            pace_left    = rsp_hold_req;
            rsp_hold_req = 0;
         end else if (pace_left == 0) begin
            pace_on   = ~pace_on;
            pace_left = pace_on ? pick_run() : pick_gap();
            if (pace_left == 0) begin
               pace_on   = 1'b1;
               pace_left = pick_run();
            end
         end
         rsp_ready <= pace_on;
         pace_left--;
      end
   end

   // Compare each frame byte with the oldest expectation
   always @(posedge clock) begin : frame_check
      frame_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_bytes.size() == 0) begin
            $error("frame_byte: expected none, got %02h", rsp_frame_byte);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_frame_byte !== want.frame_byte) begin
               $error("frame_byte: expected %02h, got %02h", want.frame_byte, rsp_frame_byte);
               fail_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_frame_end);
               fail_count++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready) ||
             csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   //--------------------------------------------------------------------------
   // Request side
   //--------------------------------------------------------------------------
   // Valid is left high after acceptance; the next item or a drain decides
   task automatic send_item(input strip_cmd_type c);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= c.action;
      req_brightness <= c.brightness;
      req_red        <= c.red;
      req_green      <= c.green;
      req_blue       <= c.blue;
      req_duration   <= c.duration;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_item(c);
   endtask

   task automatic wait_frames_drained();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_REFRESH) refresh_setting = data[COL_W-1:0];
   endtask

   task automatic csr_check_refresh();
      logic [31:0] got;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_REFRESH;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got[COL_W-1:0] !== refresh_setting) begin
         $error("refresh_ticks: expected %0d, got %0d", refresh_setting, got[COL_W-1:0]);
         fail_count++;
      end
   endtask

   // Idle-time register change
   task automatic set_refresh(input logic [COL_W-1:0] value);
      wait_frames_drained();
      csr_write(ADDR_REFRESH, {24'd0, value});
      csr_check_refresh();
   endtask

   function automatic strip_cmd_type make_cmd(input logic [ACT_W-1:0] action,
                                              input logic [COL_W-1:0] br,
                                              input logic [COL_W-1:0] r,
                                              input logic [COL_W-1:0] g,
                                              input logic [COL_W-1:0] b,
                                              input logic [DUR_W-1:0] dur);
      strip_cmd_type c;
      c.action     = action;
      c.brightness = br;
      c.red        = r;
      c.green      = g;
      c.blue       = b;
      c.duration   = dur;
      return c;
   endfunction

   function automatic logic [COL_W-1:0] rand_level();
      if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return COL_W'($urandom_range(0, 255));
   endfunction

   function automatic strip_cmd_type rand_cmd(input logic [ACT_W-1:0] action);
      strip_cmd_type c;
      int unsigned   pick;
      c.action = action;
      pick = $urandom_range(0, 3);
      if (pick == 0) c.brightness = COL_W'($urandom_range(0, 35));
      else if (pick == 1) c.brightness = $urandom_range(0, 1) ? 8'd31 : 8'd32;
      else c.brightness = COL_W'($urandom_range(0, 255));
      c.red   = rand_level();
      c.green = rand_level();
      c.blue  = rand_level();
      pick = $urandom_range(0, 9);
      if (pick < 7) c.duration = DUR_W'($urandom_range(0, 5));
      else if (pick < 9) c.duration = DUR_W'($urandom_range(6, 24));
      else c.duration = DUR_W'($urandom_range(0, 65535));
      return c;
   endfunction

   //--------------------------------------------------------------------------
   // Tests
   //--------------------------------------------------------------------------
   // Default register value; idle ticks and unused codes produce nothing
   task automatic test_power_up();
      csr_check_refresh();
      send_item(rand_cmd(ACT_TICK));
      send_item(rand_cmd(ACT_UNUSED_LO));
      send_item(rand_cmd(ACT_UNUSED_HI));
      wait_frames_drained();
   endtask

   // Set colour with clamped brightness, refresh wait, then all off
   task automatic test_set_and_off();
      send_item(make_cmd(ACT_SET, 8'hFF, 8'hFF, 8'h00, 8'hAA, 16'hFFFF));
      send_item(make_cmd(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
      send_item(make_cmd(ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
      send_item(make_cmd(ACT_OFF, 8'h00, 8'h55, 8'hAA, 8'h55, 16'h5555));
      send_item(make_cmd(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
      wait_frames_drained();
   endtask

   // Zero-length ramp jumps to target; short ramp moves channels up and down
   task automatic test_ramp_endpoints();
      send_item(make_cmd(ACT_SET, 8'd32, 8'h00, 8'hFF, 8'h0A, 16'd0));
      send_item(make_cmd(ACT_RAMP, 8'd0, 8'hFF, 8'h00, 8'hFF, 16'd0));
      send_item(rand_cmd(ACT_TICK));
      send_item(rand_cmd(ACT_TICK));
      send_item(make_cmd(ACT_RAMP, 8'hFF, 8'h00, 8'hFF, 8'h00, 16'd3));
      repeat (5) send_item(rand_cmd(ACT_TICK));
      wait_frames_drained();
   endtask

   // Zero half period: off and lit frames alternate every tick
   task automatic test_blink_fast();
      send_item(make_cmd(ACT_BLINK, 8'd31, 8'h12, 8'h34, 8'h56, 16'd0));
      repeat (3) send_item(rand_cmd(ACT_TICK));
      wait_frames_drained();
   endtask

   // Refresh period at and near its extremes, zero included
   task automatic test_refresh_register();
      logic [COL_W-1:0] settings [4];
      settings = '{8'd1, 8'd0, 8'd255, 8'd2};
      foreach (settings[i]) begin
         set_refresh(settings[i]);
         send_item(rand_cmd(ACT_SET));
         repeat (3) send_item(rand_cmd(ACT_TICK));
      end
      wait_frames_drained();
   endtask

   // Receiver stalls long while ticks keep coming, so the block backs up
   task automatic test_output_backpressure();
      set_refresh(8'd1);
      send_item(rand_cmd(ACT_SET));
      sender_gaps  = 1'b0;
      rsp_hold_req = HOLD_CYCLES;
      repeat (6) send_item(rand_cmd(ACT_TICK));
      sender_gaps = 1'b1;
      wait_frames_drained();
   endtask

   // One command followed by a burst of ticks, or a stray item
   task automatic run_episode(inout int sent);
      strip_cmd_type c;
      int unsigned   ticks;
      if ($urandom_range(0, 99) < 10) begin
         c = rand_cmd(ACT_W'($urandom_range(0, ACT_UNUSED_HI)));
         send_item(c);
         if (c.action <= ACT_BLINK) sent++;
      end else begin
         send_item(rand_cmd(ACT_W'($urandom_range(ACT_OFF, ACT_BLINK))));
         sent++;
         ticks = $urandom_range(1, 8);
         repeat (ticks) begin
            send_item(rand_cmd(ACT_TICK));
            sent++;
         end
      end
   endtask

   // Chunks of random effect sequences; the sender drains between chunks
   task automatic test_random_traffic();
      int sent;
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         case (chunk)
            0:       set_refresh(8'd1);
            2:       set_refresh(8'd0);
            default: set_refresh(COL_W'($urandom_range(1, 4)));
         endcase
         sender_gaps = (chunk != 2);
         sent = 0;
         while (sent < CHUNK_ITEMS) run_episode(sent);
      end
      sender_gaps = 1'b1;
   endtask

   initial begin
      model_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_up();
      test_set_and_off();
      test_ramp_endpoints();
      test_blink_fast();
      test_refresh_register();
      test_output_backpressure();
      test_random_traffic();
      wait_frames_drained();
      repeat (2 * FRAME_LEN) @(posedge clock);
      if (fail_count == 0 && expected_bytes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/lsfg_pkg.sv
hw/rtl/lsfg_div.sv
hw/rtl/led_strip_effect_frame_generator_unit.sv
tb/tb_led_strip_effect_frame_generator_unit.sv
